@@ sv/spq_pkg.sv @@
// Shared constants, request/status/move codes and cell control types
// for the sorted priority queue. No dependencies.
`default_nettype none

package spq_pkg;

    // Sizing
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int ID_W     = 16;
    localparam int REQ_W    = 3;
    localparam int POS_W    = 5;
    localparam int STS_W    = 3;

    // Request codes
    localparam logic [REQ_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] OP_POP     = 3'd1;
    localparam logic [REQ_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [REQ_W-1:0] OP_LOCATE  = 3'd3;
    localparam logic [REQ_W-1:0] OP_REMOVE  = 3'd4;
    localparam logic [REQ_W-1:0] OP_PROMOTE = 3'd5;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_EMPTY     = 3'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd2;
    localparam logic [STS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STS_W-1:0] STS_AT_HEAD   = 3'd4;
    localparam logic [STS_W-1:0] STS_INVALID   = 3'd5;

    // Cell move codes
    localparam logic [2:0] MV_HOLD    = 3'd0;
    localparam logic [2:0] MV_INSERT  = 3'd1;
    localparam logic [2:0] MV_POP     = 3'd2;
    localparam logic [2:0] MV_DELETE  = 3'd3;
    localparam logic [2:0] MV_PROMOTE = 3'd4;

    localparam logic [ID_W-1:0] ID_FIRST = 16'd1;
    localparam logic [ID_W-1:0] ID_LAST  = 16'hFFFF;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic [2:0]       move;
        logic [VAL_W-1:0] cmp_val;   // value compared for insert
        logic [VAL_W-1:0] load_val;  // value loaded by insert or promote
        logic [ID_W-1:0]  load_id;   // id loaded by insert or promote
        logic [ID_W-1:0]  tid;       // id searched for
    } t_cell_ctl;

    // Prefix flags handed from cell to cell, head toward tail
    typedef struct packed {
        logic ins_seen;    // insert point lies at an earlier cell
        logic match_seen;  // id match lies at an earlier cell
    } t_link;

endpackage : spq_pkg

`default_nettype wire

@@ sv/spq_cell.sv @@
// One slot of the queue: holds a value and an id, compares against the
// broadcast request and shifts from its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_valid,      // slot is occupied
    input  wire logic             i_head,       // slot is position 1
    input  wire t_link            i_link,
    output t_link                 o_link,
    input  wire logic [VAL_W-1:0] i_left_val,
    input  wire logic [ID_W-1:0]  i_left_id,
    input  wire logic [VAL_W-1:0] i_right_val,
    input  wire logic [ID_W-1:0]  i_right_id,
    output logic [VAL_W-1:0]      o_val,
    output logic [ID_W-1:0]       o_id,
    output logic                  o_first_match
);

    logic [VAL_W-1:0] r_val, n_val;
    logic [ID_W-1:0]  r_id, n_id;
    logic             ins_cand;
    logic             match;

    // Insert goes at the head on a tie, elsewhere before a strictly smaller value
    assign ins_cand = !i_valid ||
                      (i_head ? (r_val <= i_ctl.cmp_val) : (r_val < i_ctl.cmp_val));
    assign match    = i_valid && (r_id == i_ctl.tid);

    assign o_link.ins_seen   = i_link.ins_seen | ins_cand;
    assign o_link.match_seen = i_link.match_seen | match;
    assign o_first_match     = match && !i_link.match_seen;

    // Select the next contents
    always_comb begin
        n_val = r_val;
        n_id  = r_id;
        case (i_ctl.move)
            MV_INSERT: begin
                if (i_link.ins_seen) begin
                    n_val = i_left_val;
                    n_id  = i_left_id;
                end else if (ins_cand) begin
                    n_val = i_ctl.load_val;
                    n_id  = i_ctl.load_id;
                end
            end
            MV_POP: begin
                n_val = i_right_val;
                n_id  = i_right_id;
            end
            MV_DELETE: begin
                if (i_link.match_seen || match) begin
                    n_val = i_right_val;
                    n_id  = i_right_id;
                end
            end
            MV_PROMOTE: begin
                if (i_head) begin
                    n_val = i_ctl.load_val;
                    n_id  = i_ctl.load_id;
                end else if (!i_link.match_seen) begin
                    n_val = i_left_val;
                    n_id  = i_left_id;
                end
            end
            default: begin
                n_val = r_val;
                n_id  = r_id;
            end
        endcase
    end

    // Hold the slot contents
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_id  <= n_id;
    end

    assign o_val = r_val;
    assign o_id  = r_id;

endmodule : spq_cell

`default_nettype wire

@@ sv/sorted_priority_queue_with_ids.sv @@
// Top level of the sorted priority queue: request decode, occupancy and id
// counters, and the row of spq_cell slots. Depends on spq_pkg and spq_cell.
//
// Each request is taken at an edge where start is high and busy is low, then
// busy stays high for one cycle in which every slot compares against the
// request at once and the whole row shifts in that same cycle; the first-match
// and insert-point flags ripple from slot to slot along the row, and that
// ripple sets the cycle time. The result word is shown for exactly one cycle,
// marked by o_valid, in the cycle after the work cycle, and a new request may
// be started in that same cycle. The receiver cannot stall the result, so it
// must take every word as it appears.
`default_nettype none

module sorted_priority_queue_with_ids import spq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire logic [VAL_W-1:0] i_item_value,
    input  wire logic [ID_W-1:0]  i_target_id,
    output logic                  o_valid,
    output logic [ID_W-1:0]       o_result_id,
    output logic [POS_W-1:0]      o_position,
    output logic [POS_W-1:0]      o_entry_count,
    output logic [STS_W-1:0]      o_status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic             r_state, n_state;
    logic [REQ_W-1:0] r_req;
    logic [VAL_W-1:0] r_val;
    logic [ID_W-1:0]  r_tid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic             r_valid;
    logic [ID_W-1:0]  r_result_id, n_result_id;
    logic [POS_W-1:0] r_position, n_position;
    logic [STS_W-1:0] r_status, n_status;

    logic             accept;
    logic             empty;
    logic             full;
    logic             found;
    logic [2:0]       move;
    t_cell_ctl        cell_ctl;

    t_link            links      [CAPACITY+1];
    logic [VAL_W-1:0] cell_val   [CAPACITY];
    logic [ID_W-1:0]  cell_id    [CAPACITY];
    logic             cell_valid [CAPACITY];
    logic             first_hit  [CAPACITY];

    logic [VAL_W-1:0] hit_val;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] hit_pos;

    assign busy   = (r_state == ST_WORK);
    assign accept = start && !busy;
    assign empty  = (r_count == '0);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign found  = links[CAPACITY].match_seen;

    // Gather the value and index of the first matching slot
    always_comb begin
        hit_val = '0;
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_val = hit_val | (cell_val[i] & {VAL_W{first_hit[i]}});
            hit_idx = hit_idx | (IDX_W'(i) & {IDX_W{first_hit[i]}});
        end
    end
    assign hit_pos = CNT_W'(hit_idx) + CNT_W'(1);

    // Decode the request in the work cycle
    always_comb begin
        move        = MV_HOLD;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_result_id = '0;
        n_position  = '0;
        n_status    = STS_OK;
        unique case (r_req) inside
            OP_INSERT: begin
                if (full) begin
                    n_status = STS_FULL;
                end else begin
                    move        = MV_INSERT;
                    n_result_id = r_next_id;
                    n_count     = r_count + CNT_W'(1);
                    n_next_id   = (r_next_id == ID_LAST) ? ID_FIRST : r_next_id + ID_FIRST;
                end
            end
            OP_POP, OP_PEEK: begin
                if (empty) begin
                    n_status = STS_EMPTY;
                end else begin
                    n_result_id = cell_id[0];
                    if (r_req == OP_POP) begin
                        move    = MV_POP;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            OP_LOCATE, OP_REMOVE, OP_PROMOTE: begin
                if (empty) begin
                    n_status = STS_EMPTY;
                end else if (!found) begin
                    n_status = STS_NOT_FOUND;
                end else begin
                    n_result_id = r_tid;
                    if (r_req == OP_LOCATE) begin
                        n_position = POS_W'(hit_pos);
                    end else if (r_req == OP_REMOVE) begin
                        move    = MV_DELETE;
                        n_count = r_count - CNT_W'(1);
                    end else if (first_hit[0]) begin
                        n_status = STS_AT_HEAD;
                    end else begin
                        move = MV_PROMOTE;
                    end
                end
            end
            default: begin
                n_status = STS_INVALID;
            end
        endcase
    end

    // Broadcast to the row; slots move only in the work cycle
    always_comb begin
        cell_ctl.move     = busy ? move : MV_HOLD;
        cell_ctl.cmp_val  = r_val;
        cell_ctl.load_val = (r_req == OP_INSERT) ? r_val : hit_val;
        cell_ctl.load_id  = (r_req == OP_INSERT) ? r_next_id : r_tid;
        cell_ctl.tid      = r_tid;
    end

    assign links[0] = '0;

    // Row of slots, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] left_val, right_val;
        logic [ID_W-1:0]  left_id, right_id;

        if (g == 0) begin : g_head
            assign left_val = '0;
            assign left_id  = '0;
        end else begin : g_body
            assign left_val = cell_val[g-1];
            assign left_id  = cell_id[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = '0;
            assign right_id  = '0;
        end else begin : g_inner
            assign right_val = cell_val[g+1];
            assign right_id  = cell_id[g+1];
        end

        assign cell_valid[g] = (CNT_W'(g) < r_count);

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_valid       (cell_valid[g]),
            .i_head        (g == 0),
            .i_link        (links[g]),
            .o_link        (links[g+1]),
            .i_left_val    (left_val),
            .i_left_id     (left_id),
            .i_right_val   (right_val),
            .i_right_id    (right_id),
            .o_val         (cell_val[g]),
            .o_id          (cell_id[g]),
            .o_first_match (first_hit[g])
        );
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_next_id <= ID_FIRST;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= busy;
            if (busy) begin
                r_count   <= n_count;
                r_next_id <= n_next_id;
            end
        end
    end

    // Capture the request word and the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_val <= i_item_value;
            r_tid <= i_target_id;
        end
        if (busy) begin
            r_result_id <= n_result_id;
            r_position  <= n_position;
            r_status    <= n_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_id   = r_result_id;
    assign o_position    = r_position;
    assign o_entry_count = POS_W'(r_count);
    assign o_status      = r_status;

    // Checks
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("result word missing after work cycle");

    a_strobe_only_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_next_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("id counter reached zero");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_req == OP_INSERT && !full)
            |=> (r_count == $past(r_count) + CNT_W'(1)) && (o_status == STS_OK))
        else $error("insert did not add an entry");

endmodule : sorted_priority_queue_with_ids

`default_nettype wire
